@@ src/prx_pkg.sv @@
// Shared types, constants and helpers for the printable run extractor.
// No dependencies; the run buffer, the controller and the top level import this package.
package prx_pkg;

    // Default run buffer depth; the top level's MAX_RUN takes it as its default.
    localparam int PRX_MAX_RUN = 64;

    // Width of the buffer address carried in t_buf_req (covers MAX_RUN up to 256).
    localparam int PRX_ADDR_W = 8;

    localparam logic [7:0] PRX_MIN_RESET = 8'd4;
    localparam logic [7:0] CHAR_TAB      = 8'd9;
    localparam logic [7:0] CHAR_SPACE    = 8'd32;
    localparam logic [7:0] CHAR_DEL      = 8'd127;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    // Request from the controller to the run buffer.
    typedef struct packed {
        logic                  we;
        logic [PRX_ADDR_W-1:0] waddr;
        logic [7:0]            wdata;
        logic                  re;
        logic [PRX_ADDR_W-1:0] raddr;
    } t_buf_req;

    function automatic logic is_printable(input logic [7:0] c);
        return ((c >= CHAR_SPACE) && (c < CHAR_DEL)) || (c == CHAR_TAB);
    endfunction

endpackage

@@ src/prx_ifs.sv @@
// Valid/ready channel interfaces: input byte beats, output character beats
// and the configuration write channel. No dependencies.
interface prx_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, kind, data_byte, input ready);
    modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface prx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       run_last;

    modport source (output valid, char_out, run_last, input ready);
    modport sink   (input valid, char_out, run_last, output ready);
endinterface

interface prx_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ src/printable_run_extractor_core.sv @@
// Printable run extractor, top level: run buffer memory plus controller.
// Depends on prx_pkg, prx_ifs, prx_run_buf, prx_ctrl.
//
// Takes one byte beat per cycle on i_in while collecting and collects runs of printable
// bytes (32..126 and tab) into a MAX_RUN-entry run buffer; bytes past a full
// buffer are dropped but the run stays open. A non-printable byte, or a beat
// with kind = 1 (end of input), closes the run. If the stored length is at
// least min_run_length (zero counts as one), the stored characters are sent
// on o_out in order, run_last marking the final one; the closing byte is never
// sent. Timing: while collecting, one input beat is taken every cycle. A
// closing beat that emits a run of N characters holds i_in.ready low until the
// last character has been taken; the pace of emission is set by the run
// buffer's single read port with registered data and the one output register
// (one read in flight at a time). A closing beat that emits nothing leaves
// i_in.ready high. Writes to i_cfg (min_run_length) are always taken and
// belong while the block is idle. The buffer needs no clearing after reset:
// only entries written in the current run are ever read.
module printable_run_extractor_core
    import prx_pkg::*;
#(
    parameter int MAX_RUN = PRX_MAX_RUN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prx_in_if.sink     i_in,
    prx_out_if.source  o_out,
    prx_cfg_if.sink    i_cfg
);

    t_buf_req   buf_req;
    logic [7:0] buf_rdata;

    // controller: collect/emit sequencing, length counter, output register
    prx_ctrl #(
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .o_req   (buf_req),
        .i_rdata (buf_rdata)
    );

    // run buffer; writes only while collecting, reads only while emitting,
    // so the two ports never touch the same entry in one cycle
    prx_run_buf #(
        .MAX_RUN (MAX_RUN)
    ) u_buf (
        .i_clk   (i_clk),
        .i_req   (buf_req),
        .o_rdata (buf_rdata)
    );

endmodule

@@ src/prx_run_buf.sv @@
// Run buffer: MAX_RUN x 8 bit synchronous memory, one write and one read port,
// read data registered. Depends on prx_pkg.
module prx_run_buf
    import prx_pkg::*;
#(
    parameter int MAX_RUN = PRX_MAX_RUN
) (
    input  logic       i_clk,
    input  t_buf_req   i_req,
    output logic [7:0] o_rdata
);

    localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    logic [7:0] mem [MAX_RUN];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= mem[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/prx_ctrl.sv @@
// Controller: run length counter, minimum length register, collect/emit FSM,
// buffer read sequencing and the output register. Depends on prx_pkg, prx_ifs.
module prx_ctrl
    import prx_pkg::*;
#(
    parameter int MAX_RUN = PRX_MAX_RUN
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    prx_in_if.sink       i_in,
    prx_out_if.source    o_out,
    prx_cfg_if.sink      i_cfg,
    output t_buf_req     o_req,
    input  logic [7:0]   i_rdata
);

    localparam int LW = $clog2(MAX_RUN + 1);

    t_state          r_state, n_state;
    logic [LW-1:0]   r_len;
    logic [LW-1:0]   r_emit_len;
    logic [LW-1:0]   r_rd_cnt;
    logic [7:0]      r_min;
    logic            r_pend;
    logic            r_pend_last;
    logic            r_out_valid;
    logic [7:0]      r_out_char;
    logic            r_out_last;

    logic            in_ready;
    logic            in_beat;
    logic            out_beat;
    logic            close_run;
    logic            store;
    logic            emit_ok;
    logic            issue;
    logic            issue_last;
    logic [8:0]      need;

    // ---- datapath terms
    assign in_beat  = i_in.valid && in_ready;
    assign out_beat = r_out_valid && o_out.ready;
    assign close_run = in_beat && (i_in.kind || !is_printable(i_in.data_byte));
    assign store     = in_beat && !i_in.kind && is_printable(i_in.data_byte)
                       && (r_len < LW'(MAX_RUN));
    // a minimum of zero acts as one, so an empty run never goes out
    assign need    = (r_min == 8'd0) ? 9'd1 : {1'b0, r_min};
    assign emit_ok = (9'(r_len) >= need);
    assign issue_last = (({1'b0, r_rd_cnt} + (LW+1)'(1)) == {1'b0, r_emit_len});

    // ---- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (close_run && emit_ok) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_beat && r_out_last) begin
                    n_state = ST_COLLECT;
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    // ---- state outputs
    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        unique case (r_state)
            ST_COLLECT: in_ready = 1'b1;
            ST_EMIT: begin
                // read only when the output register is free by the time data lands
                issue = !r_pend && (r_rd_cnt < r_emit_len) && (!r_out_valid || o_out.ready);
            end
            default: ;
        endcase
    end

    always_comb begin
        o_req.we    = store;
        o_req.waddr = PRX_ADDR_W'(r_len);
        o_req.wdata = i_in.data_byte;
        o_req.re    = issue;
        o_req.raddr = PRX_ADDR_W'(r_rd_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_COLLECT;
            r_len       <= '0;
            r_emit_len  <= '0;
            r_rd_cnt    <= '0;
            r_min       <= PRX_MIN_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_min <= i_cfg.data;
            end
            if (close_run) begin
                r_len      <= '0;
                r_emit_len <= r_len;
                r_rd_cnt   <= '0;
            end else if (store) begin
                r_len <= r_len + LW'(1);
            end
            if (issue) begin
                r_rd_cnt <= r_rd_cnt + LW'(1);
            end
            r_pend <= issue;
            if (r_pend) begin
                r_out_valid <= 1'b1;
            end else if (out_beat) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_last <= issue_last;
        end
        if (r_pend) begin
            r_out_char <= i_rdata;
            r_out_last <= r_pend_last;
        end
    end

    assign i_in.ready     = in_ready;
    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_out_valid;
    assign o_out.char_out = r_out_char;
    assign o_out.run_last = r_out_last;

endmodule

@@ src/prx_checker.sv @@
// Port-level checker for the printable run extractor, bound to the top level.
// Depends on printable_run_extractor_core and the prx channel interfaces.
module prx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // a waiting character holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
                                        && $stable(i_out_last))
        else $error("output beat changed while stalled");

    // input is held off while a run is going out
    a_in_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready during emission");

    // a burst continues until its last character
    a_burst_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> !i_in_ready)
        else $error("input reopened mid-burst");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind printable_run_extractor_core prx_checker u_prx_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_out),
    .i_out_last  (o_out.run_last)
);
